FILE: src/fbpa_pkg.sv
// Shared types, codes and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CFG_CNT_W  = 9;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned FREE_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MAX_BLOCKS_DEF = 256;

  // Register reset values
  localparam logic [ADDR_W-1:0]    BASE_RST  = '0;
  localparam logic [SIZE_W-1:0]    SIZE_RST  = 16'd8;
  localparam logic [CFG_CNT_W-1:0] COUNT_RST = 9'd256;
  localparam int unsigned          COUNT_RST_INT = 256;

  // Smallest block: one link word
  localparam logic [SIZE_W-1:0] MIN_BLOCK_BYTES = 16'd8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_OUTSIDE    = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_NOT_IN_USE = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_SIZE  = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
    logic [FREE_W-1:0]   free_blocks;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_req;
    logic setup;
    logic mul_idx;
    logic div_start;
    logic latch_quot;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            alloc_empty;
    logic            outside;
    logic            div_busy;
  } flags_t;

endpackage

FILE: src/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/fbpa_div.sv
// Restoring divider: one quotient bit per cycle, offset by block size.
module fbpa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend_i,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic [fbpa_pkg::ADDR_W-1:0] quot_o,
  output logic [fbpa_pkg::SIZE_W-1:0] rem_o
);
  import fbpa_pkg::*;

  localparam int unsigned CNT_W = $clog2(ADDR_W + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] quo_q, quo_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[ADDR_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ADDR_W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[ADDR_W-2:0], fits};
      rem_d = fits ? SIZE_W'(trial - {1'b0, divisor_i}) : trial[SIZE_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: src/fbpa_dp.sv
// Datapath: configuration, free list head, link and mark memories, address math.
module fbpa_dp #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fbpa_pkg::req_t                 in_data_i,
  input  logic                           cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  fbpa_pkg::cmd_t                 cmd_i,
  output fbpa_pkg::flags_t               flags_o,
  output fbpa_pkg::rsp_t                 rsp_o
);
  import fbpa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SPAN_W  = CNT_W + SIZE_W;
  localparam int unsigned CMP_W   = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
  localparam int unsigned RST_CNT =
    (MAX_BLOCKS < COUNT_RST_INT) ? MAX_BLOCKS : COUNT_RST_INT;

  // Configuration
  logic [ADDR_W-1:0]    base_q;
  logic [SIZE_W-1:0]    size_q;
  logic [CFG_CNT_W-1:0] count_q;
  logic [SIZE_W-1:0]    eff_size;
  logic [CNT_W-1:0]     eff_cnt;

  // Request and working registers
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] offset_q;
  logic              below_q;
  logic [SPAN_W-1:0] mul_q, mul_d;
  logic [CNT_W-1:0]  mul_a;
  logic [IDX_W-1:0]  idx_q;

  // Free list state
  logic [IDX_W-1:0] head_q, head_d;
  logic             empty_q, empty_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] wmark_q, wmark_d;  // blocks below this still sit in the rebuilt run
  logic [CNT_W-1:0] nreb_q, nreb_d;    // block count of the last rebuild

  rsp_t rsp_q;

  logic              div_busy;
  logic [ADDR_W-1:0] div_quot;
  logic [SIZE_W-1:0] div_rem;

  logic [IDX_W-1:0] link_rd;
  logic             mark_rd;
  logic             link_we, mark_we;
  logic [IDX_W-1:0] link_wdata;

  logic             alloc_empty, outside, idx_below, untouched, used;
  logic             alloc_ok, free_ok;
  logic [IDX_W-1:0] next_head;
  status_e          status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      size_q  <= SIZE_RST;
      count_q <= COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE:  base_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_size = (size_q < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : size_q;

  always_comb begin
    if (count_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(count_q) > 32'(MAX_BLOCKS)) begin
      eff_cnt = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_cnt = CNT_W'(count_q);
    end
  end

  // One shared multiplier: pool span on setup, block offset for allocate
  assign mul_a = cmd_i.mul_idx ? CNT_W'(idx_q) : eff_cnt;
  assign mul_d = SPAN_W'(mul_a) * SPAN_W'(eff_size);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      op_q   <= in_data_i.operation;
      addr_q <= in_data_i.address;
    end
    if (cmd_i.setup) begin
      offset_q <= addr_q - base_q;
      below_q  <= addr_q < base_q;
      idx_q    <= head_q;
    end
    if (cmd_i.setup || cmd_i.mul_idx) begin
      mul_q <= mul_d;
    end
    if (cmd_i.latch_quot) begin
      idx_q <= div_quot[IDX_W-1:0];
    end
    if (cmd_i.commit) begin
      rsp_q.status        <= status;
      rsp_q.block_address <= alloc_ok ? ADDR_W'(base_q + ADDR_W'(mul_q)) : '0;
      rsp_q.free_blocks   <= FREE_W'(free_d);
    end
  end

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (offset_q),
    .divisor_i  (eff_size),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign alloc_empty = empty_q || (free_q == '0);
  assign outside     = below_q || (CMP_W'(offset_q) >= CMP_W'(mul_q));

  // Entries below the watermark or past the rebuilt count are untouched since
  // the last rebuild: their link is the next lower block and their mark clear.
  assign idx_below = CNT_W'(idx_q) < wmark_q;
  assign untouched = idx_below || (CNT_W'(idx_q) >= nreb_q);
  assign used      = !untouched && mark_rd;
  assign next_head = idx_below ? ((idx_q == '0) ? '0 : idx_q - IDX_W'(1)) : link_rd;

  always_comb begin
    unique case (op_q)
      OP_ALLOC: status = alloc_empty ? ST_EMPTY : ST_OK;
      OP_FREE: begin
        priority if (outside) begin
          status = ST_OUTSIDE;
        end else if (div_rem != '0) begin
          status = ST_MISALIGNED;
        end else if (!used) begin
          status = ST_NOT_IN_USE;
        end else begin
          status = ST_OK;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign alloc_ok = (op_q == OP_ALLOC) && !alloc_empty;
  assign free_ok  = (op_q == OP_FREE) && (status == ST_OK);

  always_comb begin
    head_d  = head_q;
    empty_d = empty_q;
    free_d  = free_q;
    wmark_d = wmark_q;
    nreb_d  = nreb_q;
    if (alloc_ok) begin
      free_d = free_q - CNT_W'(1);
      if (free_q == CNT_W'(1)) begin
        empty_d = 1'b1;
      end else begin
        head_d = next_head;
      end
      if (idx_below) begin
        wmark_d = CNT_W'(idx_q);
      end
    end else if (free_ok) begin
      head_d  = idx_q;
      empty_d = 1'b0;
      free_d  = free_q + CNT_W'(1);
    end else if (op_q == OP_RESET) begin
      head_d  = IDX_W'(eff_cnt - CNT_W'(1));
      empty_d = 1'b0;
      free_d  = eff_cnt;
      wmark_d = eff_cnt;
      nreb_d  = eff_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= IDX_W'(RST_CNT - 1);
      empty_q <= 1'b0;
      free_q  <= CNT_W'(RST_CNT);
      wmark_q <= CNT_W'(RST_CNT);
      nreb_q  <= CNT_W'(RST_CNT);
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      empty_q <= empty_d;
      free_q  <= free_d;
      wmark_q <= wmark_d;
      nreb_q  <= nreb_d;
    end
  end

  assign link_we    = cmd_i.commit && free_ok;
  assign link_wdata = empty_q ? '0 : head_q;
  assign mark_we    = cmd_i.commit && (alloc_ok || free_ok);

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (idx_q),
    .wdata_i (link_wdata),
    .raddr_i (idx_q),
    .rdata_o (link_rd)
  );

  fbpa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLOCKS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (idx_q),
    .wdata_i (alloc_ok),
    .raddr_i (idx_q),
    .rdata_o (mark_rd)
  );

  assign flags_o.op          = op_q;
  assign flags_o.alloc_empty = alloc_empty;
  assign flags_o.outside     = outside;
  assign flags_o.div_busy    = div_busy;
  assign rsp_o               = rsp_q;

endmodule

FILE: src/fbpa_ctrl.sv
// Controller: sequences one request at a time and owns the handshakes.
module fbpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  fbpa_pkg::flags_t flags_i,
  output fbpa_pkg::cmd_t   cmd_o
);
  import fbpa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_AMUL   = 3'd2;
  localparam logic [2:0] S_FCHK   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_FMARK  = 3'd5;
  localparam logic [2:0] S_FREAD  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  // Output register can take a word when empty or being drained
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch_req = in_valid_i;
        if (in_valid_i) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (flags_i.op == OP_ALLOC) begin
          state_d = flags_i.alloc_empty ? S_FINISH : S_AMUL;
        end else if (flags_i.op == OP_FREE) begin
          state_d = S_FCHK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_AMUL: begin
        cmd_o.mul_idx = 1'b1;
        state_d       = S_FINISH;
      end
      S_FCHK: begin
        if (flags_i.outside) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (!flags_i.div_busy) begin
          state_d = S_FMARK;
        end
      end
      S_FMARK: begin
        cmd_o.latch_quot = 1'b1;
        state_d          = S_FREAD;
      end
      S_FREAD: state_d = S_FINISH;
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO free list over equal blocks at a base address.
// One request is in work at a time; the result word sits in an output register, so
// the next request is taken while the previous result waits. Allocate steps through the
// list head, the link memory read and the index times block size; reset pool and an
// empty-list allocate skip the multiply, a free that falls outside the pool stops after
// the range check, and any other free waits on the bit-per-cycle divider that splits
// the offset into block index and remainder (32 steps), then reads the used mark.
// A new request is taken in the cycle after the result is written. Reset and the reset
// pool operation rebuild the list through a watermark, with no clearing pass, so the
// block is ready right after reset. Configuration writes belong in idle periods.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fbpa_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fbpa_pkg::rsp_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fbpa_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .rsp_o       (out_data_o)
  );

endmodule

FILE: src/fbpa_checker.sv
// Port-level checks of the pool allocator, bound to the top level.
module fbpa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input fbpa_pkg::rsp_t out_data_o
);
  import fbpa_pkg::*;

  // A taken request blocks the input until its result is written
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another was in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.block_address == '0)
    else $error("failed request returned an address");

  a_empty_none_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |-> out_data_o.free_blocks == '0)
    else $error("empty status with free blocks left");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
